@@ hw/rtl/lfos_pkg.sv @@
// Shared types and constants for the line follow / obstacle sequencer.
// Holds the action and mode codes, register indexes, reset values and the step plan struct.
// No dependencies.
`timescale 1ns / 1ps

package lfos_pkg;

  // Line sensor configuration: only the eight present bits are ever examined.
  localparam int SENSOR_COUNT = 8;
  localparam int SENSOR_BITS  = 8;
  localparam logic [SENSOR_BITS-1:0] SENSOR_MASK =
    (SENSOR_COUNT >= SENSOR_BITS) ? {SENSOR_BITS{1'b1}} :
    SENSOR_BITS'((64'd1 << SENSOR_COUNT) - 64'd1);

  // Motor command codes.
  typedef enum logic [2:0] {
    ACT_STOP   = 3'd0,
    ACT_FWD    = 3'd1,
    ACT_REV    = 3'd2,
    ACT_SPIN_R = 3'd3,
    ACT_SPIN_L = 3'd4,
    ACT_DIFF   = 3'd5
  } action_t;

  // Operating modes.
  typedef enum logic [1:0] {
    MODE_FOLLOW = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_TURN_R = 2'd2,
    MODE_TURN_L = 2'd3
  } mode_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN_P       = 3'd0;
  localparam logic [2:0] REG_GAIN_D       = 3'd1;
  localparam logic [2:0] REG_CRUISE_SPEED = 3'd2;
  localparam logic [2:0] REG_OBSTACLE_CM  = 3'd3;
  localparam logic [2:0] REG_TURN_MS      = 3'd4;
  localparam logic [2:0] REG_SEARCH_MS    = 3'd5;

  // Configuration reset values.
  localparam logic [9:0]  GAIN_P_RST       = 10'd100;
  localparam logic [9:0]  GAIN_D_RST       = 10'd100;
  localparam logic [7:0]  CRUISE_SPEED_RST = 8'd150;
  localparam logic [8:0]  OBSTACLE_CM_RST  = 9'd15;
  localparam logic [15:0] TURN_MS_RST      = 16'd800;
  localparam logic [15:0] SEARCH_MS_RST    = 16'd2000;

  // Hold times and phase offsets of the timed maneuvers.
  localparam logic [8:0]  HOLD_NONE      = 9'd0;
  localparam logic [8:0]  HOLD_OBST_STOP = 9'd200;
  localparam logic [8:0]  HOLD_REVERSE   = 9'd500;
  localparam logic [8:0]  HOLD_SETTLE    = 9'd100;
  localparam logic [31:0] OBST_SEQ_MS    = 32'd800;
  localparam logic [31:0] SETTLE_MS      = 32'd100;

  // Divide by 100 through a reciprocal: q = (|p| * RECIP) >> 30, exact for |p| < 14e6.
  localparam int PROD_W    = 24;
  localparam int RECIP_W   = 24;
  localparam int SCALE_W   = PROD_W + RECIP_W;
  localparam int QUOT_W    = 18;
  localparam int DIV_SHIFT = 30;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 24'd10737419;

  // Adjustment and raw speed widths.
  localparam int ADJ_W = 19;
  localparam int RAW_W = 20;

  // Commands produced by one step; speeds are filled in at the output stage.
  typedef struct packed {
    logic            diff;
    logic [1:0]      cnt;
    logic [2:0][2:0] act;
    logic [2:0][8:0] hold;
  } plan_t;

endpackage

@@ hw/rtl/lfos_ctrl.sv @@
// Mode sequencer of the line follow / obstacle block, with the PD products.
// Holds mode, turn side, previous error and phase start; registers the step plan.
// Depends on lfos_pkg.
`timescale 1ns / 1ps

module lfos_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                s1_valid,
  input  logic [31:0]                         now_ms,
  input  logic [8:0]                          distance_cm,
  input  logic [7:0]                          line_sensors,
  input  logic signed [12:0]                  line_position,
  input  logic [9:0]                          gain_p,
  input  logic [9:0]                          gain_d,
  input  logic [8:0]                          obstacle_cm,
  input  logic [15:0]                         turn_ms,
  input  logic [15:0]                         search_ms,
  output logic                                s2_valid,
  output lfos_pkg::plan_t                     s2_plan,
  output logic signed [lfos_pkg::PROD_W-1:0]  s2_prod_p,
  output logic signed [lfos_pkg::PROD_W-1:0]  s2_prod_d
);

  lfos_pkg::mode_t mode, mode_next;
  logic            turn_right, turn_right_next;
  logic signed [12:0] prev_error, prev_error_next;
  logic [31:0]     phase_start, phase_start_next;

  logic [31:0]     elapsed;
  logic            obstacle;
  logic            line_seen;
  logic            turn_done;
  logic            search_over;
  logic            step;
  lfos_pkg::plan_t plan;
  logic signed [13:0] derr;
  logic signed [lfos_pkg::PROD_W-1:0] prod_p, prod_d;

  // Step conditions.
  assign step        = adv && s1_valid;
  assign elapsed     = now_ms - phase_start;
  assign obstacle    = distance_cm < obstacle_cm;
  assign line_seen   = |(line_sensors & lfos_pkg::SENSOR_MASK);
  assign turn_done   = elapsed > {16'd0, turn_ms};
  assign search_over = elapsed > {16'd0, search_ms};

  // Next state.
  always_comb begin
    mode_next        = mode;
    turn_right_next  = turn_right;
    prev_error_next  = prev_error;
    phase_start_next = phase_start;
    unique case (mode)
      lfos_pkg::MODE_FOLLOW: begin
        if (obstacle) begin
          turn_right_next  = !turn_right;
          mode_next        = turn_right ? lfos_pkg::MODE_TURN_L : lfos_pkg::MODE_TURN_R;
          phase_start_next = now_ms + lfos_pkg::OBST_SEQ_MS;
        end else begin
          prev_error_next = line_position;
        end
      end
      lfos_pkg::MODE_TURN_R, lfos_pkg::MODE_TURN_L: begin
        if (turn_done) begin
          mode_next        = lfos_pkg::MODE_SEARCH;
          phase_start_next = now_ms;
        end
      end
      lfos_pkg::MODE_SEARCH: begin
        if (line_seen) begin
          mode_next = lfos_pkg::MODE_FOLLOW;
        end else if (search_over) begin
          turn_right_next  = !turn_right;
          mode_next        = turn_right ? lfos_pkg::MODE_TURN_L : lfos_pkg::MODE_TURN_R;
          phase_start_next = now_ms + lfos_pkg::SETTLE_MS;
        end
      end
      default: mode_next = mode;
    endcase
  end

  // Command plan for this step.
  always_comb begin
    plan.diff = 1'b0;
    plan.cnt  = 2'd1;
    plan.act  = {lfos_pkg::ACT_STOP, lfos_pkg::ACT_STOP, lfos_pkg::ACT_STOP};
    plan.hold = {lfos_pkg::HOLD_NONE, lfos_pkg::HOLD_NONE, lfos_pkg::HOLD_NONE};
    unique case (mode)
      lfos_pkg::MODE_FOLLOW: begin
        if (obstacle) begin
          plan.cnt     = 2'd3;
          plan.act[1]  = lfos_pkg::ACT_REV;
          plan.hold[0] = lfos_pkg::HOLD_OBST_STOP;
          plan.hold[1] = lfos_pkg::HOLD_REVERSE;
          plan.hold[2] = lfos_pkg::HOLD_SETTLE;
        end else begin
          plan.diff   = 1'b1;
          plan.act[0] = lfos_pkg::ACT_DIFF;
        end
      end
      lfos_pkg::MODE_TURN_R, lfos_pkg::MODE_TURN_L: begin
        plan.act[0] = (mode == lfos_pkg::MODE_TURN_R) ? lfos_pkg::ACT_SPIN_R
                                                      : lfos_pkg::ACT_SPIN_L;
        if (turn_done) begin
          plan.cnt    = 2'd2;
          plan.act[1] = lfos_pkg::ACT_FWD;
        end
      end
      lfos_pkg::MODE_SEARCH: begin
        plan.act[0] = lfos_pkg::ACT_FWD;
        if (line_seen) begin
          plan.cnt    = 2'd2;
          plan.act[1] = lfos_pkg::ACT_FWD;
        end else if (search_over) begin
          plan.cnt     = 2'd2;
          plan.hold[1] = lfos_pkg::HOLD_SETTLE;
        end
      end
      default: plan.cnt = 2'd1;
    endcase
  end

  // PD products; the divide by 100 follows in the next stage.
  assign derr   = 14'(line_position) - 14'(prev_error);
  assign prod_p = lfos_pkg::PROD_W'($signed({1'b0, gain_p})) * lfos_pkg::PROD_W'(line_position);
  assign prod_d = lfos_pkg::PROD_W'($signed({1'b0, gain_d})) * lfos_pkg::PROD_W'(derr);

  // State and stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= lfos_pkg::MODE_FOLLOW;
      turn_right  <= 1'b1;
      prev_error  <= '0;
      phase_start <= '0;
      s2_valid    <= 1'b0;
    end else begin
      if (adv) begin
        s2_valid <= s1_valid;
      end
      if (step) begin
        mode        <= mode_next;
        turn_right  <= turn_right_next;
        prev_error  <= prev_error_next;
        phase_start <= phase_start_next;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_plan   <= plan;
      s2_prod_p <= prod_p;
      s2_prod_d <= prod_d;
    end
  end

endmodule

@@ hw/rtl/lfos_div100.sv @@
// Divide-by-100 stage of the line follow / obstacle block.
// Turns both PD products into quotients truncated toward zero.
// Depends on lfos_pkg.
`timescale 1ns / 1ps

module lfos_div100 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                s2_valid,
  input  lfos_pkg::plan_t                     s2_plan,
  input  logic signed [lfos_pkg::PROD_W-1:0]  s2_prod_p,
  input  logic signed [lfos_pkg::PROD_W-1:0]  s2_prod_d,
  output logic                                s3_valid,
  output lfos_pkg::plan_t                     s3_plan,
  output logic signed [lfos_pkg::QUOT_W-1:0]  s3_quot_p,
  output logic signed [lfos_pkg::QUOT_W-1:0]  s3_quot_d
);

  // Truncating divide by 100: scale the magnitude by the reciprocal, restore the sign.
  function automatic logic signed [lfos_pkg::QUOT_W-1:0] div100(
    input logic signed [lfos_pkg::PROD_W-1:0] p
  );
    logic signed [lfos_pkg::PROD_W-1:0]  neg;
    logic [lfos_pkg::PROD_W-1:0]         mag;
    logic [lfos_pkg::SCALE_W-1:0]        scaled;
    logic [lfos_pkg::QUOT_W-1:0]         q;
    neg    = -p;
    mag    = p[lfos_pkg::PROD_W-1] ? neg : p;
    scaled = {{lfos_pkg::RECIP_W{1'b0}}, mag} *
             {{lfos_pkg::PROD_W{1'b0}}, lfos_pkg::DIV_RECIP};
    q      = scaled[lfos_pkg::DIV_SHIFT +: lfos_pkg::QUOT_W];
    return p[lfos_pkg::PROD_W-1] ? -$signed(q) : $signed(q);
  endfunction

  logic signed [lfos_pkg::QUOT_W-1:0] quot_p, quot_d;

  assign quot_p = div100(s2_prod_p);
  assign quot_d = div100(s2_prod_d);

  // Stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_plan   <= s2_plan;
      s3_quot_p <= quot_p;
      s3_quot_d <= quot_d;
    end
  end

endmodule

@@ hw/rtl/lfos_out.sv @@
// Result stage of the line follow / obstacle block.
// Forms the wheel speeds, holds the step's commands and issues them one request at a time.
// Depends on lfos_pkg.
`timescale 1ns / 1ps

module lfos_out (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [7:0]                          cruise_speed,
  input  logic                                s3_valid,
  input  lfos_pkg::plan_t                     s3_plan,
  input  logic signed [lfos_pkg::QUOT_W-1:0]  s3_quot_p,
  input  logic signed [lfos_pkg::QUOT_W-1:0]  s3_quot_d,
  input  logic                                out_ready,
  output logic                                adv,
  output logic                                out_valid,
  output logic [2:0]                          motor_action,
  output logic signed [9:0]                   left_speed,
  output logic signed [9:0]                   right_speed,
  output logic [8:0]                          hold_ms,
  output logic                                last
);

  // Saturate to the symmetric wheel speed range.
  function automatic logic signed [9:0] sat511(input logic signed [lfos_pkg::RAW_W-1:0] v);
    logic signed [9:0] r;
    if (v > lfos_pkg::RAW_W'(511)) begin
      r = 10'sd511;
    end else if (v < -lfos_pkg::RAW_W'(511)) begin
      r = -10'sd511;
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

  logic                               bvalid;
  logic [1:0]                         idx;
  lfos_pkg::plan_t                    bplan;
  logic signed [9:0]                  bleft, bright;
  logic signed [lfos_pkg::ADJ_W-1:0]  adj;
  logic signed [lfos_pkg::RAW_W-1:0]  base_s, left_raw, right_raw;
  lfos_pkg::action_t                  act_cur;
  logic                               last_cmd;

  // Differential speeds from the PD adjustment.
  assign adj       = lfos_pkg::ADJ_W'(s3_quot_p) + lfos_pkg::ADJ_W'(s3_quot_d);
  assign base_s    = lfos_pkg::RAW_W'($signed({1'b0, cruise_speed}));
  assign left_raw  = base_s - lfos_pkg::RAW_W'(adj);
  assign right_raw = base_s + lfos_pkg::RAW_W'(adj);

  // Command sequencing: the stage frees up when its final command is taken.
  assign act_cur  = lfos_pkg::action_t'(bplan.act[idx]);
  assign last_cmd = (idx == (bplan.cnt - 2'd1));
  assign adv      = !bvalid || (out_ready && last_cmd);

  // Result fields.
  always_comb begin
    motor_action = act_cur;
    hold_ms      = bplan.hold[idx];
    last         = last_cmd;
    out_valid    = bvalid;
    if (bplan.diff) begin
      left_speed  = bleft;
      right_speed = bright;
    end else if (act_cur == lfos_pkg::ACT_STOP) begin
      left_speed  = '0;
      right_speed = '0;
    end else begin
      left_speed  = $signed({2'b00, cruise_speed});
      right_speed = $signed({2'b00, cruise_speed});
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      idx    <= '0;
    end else if (adv) begin
      bvalid <= s3_valid;
      idx    <= '0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      bplan  <= s3_plan;
      bleft  <= sat511(left_raw);
      bright <= sat511(right_raw);
    end
  end

endmodule

@@ hw/rtl/line_follow_obstacle_sequencer_core.sv @@
// Top level of the line follow / obstacle sequencer.
// Holds the input register and configuration registers; instantiates lfos_ctrl,
// lfos_div100 and lfos_out. Depends on lfos_pkg.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   now_ms, distance_cm, line_sensors, line_position
//   out      out_valid / out_ready motor_action, left_speed, right_speed, hold_ms, last
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// A request passes the input register, the mode/product stage, the divide stage and the
// result stage, each registered in turn, before its first command shows.
// Each request yields one to three commands, one per cycle while out_ready is high; the
// result stage takes the next request as the last command is taken, one request per burst.
// Reset restores mode, turn side, previous error, phase start, configuration; clears all valids.
// A stall on out holds the whole pipeline; in stays ready while the input register is empty.
`timescale 1ns / 1ps

module line_follow_obstacle_sequencer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        now_ms,
  input  logic [8:0]         distance_cm,
  input  logic [7:0]         line_sensors,
  input  logic signed [12:0] line_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         motor_action,
  output logic signed [9:0]  left_speed,
  output logic signed [9:0]  right_speed,
  output logic [8:0]         hold_ms,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [9:0]  gain_p, gain_d;
  logic [7:0]  cruise_speed;
  logic [8:0]  obstacle_cm;
  logic [15:0] turn_ms, search_ms;

  logic               s1_valid;
  logic [31:0]        s1_now;
  logic [8:0]         s1_dist;
  logic [7:0]         s1_sens;
  logic signed [12:0] s1_pos;
  logic               adv;
  logic               in_take;

  logic                               s2_valid;
  lfos_pkg::plan_t                    s2_plan;
  logic signed [lfos_pkg::PROD_W-1:0] s2_prod_p, s2_prod_d;
  logic                               s3_valid;
  lfos_pkg::plan_t                    s3_plan;
  logic signed [lfos_pkg::QUOT_W-1:0] s3_quot_p, s3_quot_d;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= lfos_pkg::GAIN_P_RST;
      gain_d       <= lfos_pkg::GAIN_D_RST;
      cruise_speed <= lfos_pkg::CRUISE_SPEED_RST;
      obstacle_cm  <= lfos_pkg::OBSTACLE_CM_RST;
      turn_ms      <= lfos_pkg::TURN_MS_RST;
      search_ms    <= lfos_pkg::SEARCH_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lfos_pkg::REG_GAIN_P:       gain_p       <= cfg_data[9:0];
        lfos_pkg::REG_GAIN_D:       gain_d       <= cfg_data[9:0];
        lfos_pkg::REG_CRUISE_SPEED: cruise_speed <= cfg_data[7:0];
        lfos_pkg::REG_OBSTACLE_CM:  obstacle_cm  <= cfg_data[8:0];
        lfos_pkg::REG_TURN_MS:      turn_ms      <= cfg_data;
        lfos_pkg::REG_SEARCH_MS:    search_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  assign in_ready = adv || !s1_valid;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now  <= now_ms;
      s1_dist <= distance_cm;
      s1_sens <= line_sensors;
      s1_pos  <= line_position;
    end
  end

  // Mode sequencer and PD products.
  lfos_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .s1_valid      (s1_valid),
    .now_ms        (s1_now),
    .distance_cm   (s1_dist),
    .line_sensors  (s1_sens),
    .line_position (s1_pos),
    .gain_p        (gain_p),
    .gain_d        (gain_d),
    .obstacle_cm   (obstacle_cm),
    .turn_ms       (turn_ms),
    .search_ms     (search_ms),
    .s2_valid      (s2_valid),
    .s2_plan       (s2_plan),
    .s2_prod_p     (s2_prod_p),
    .s2_prod_d     (s2_prod_d)
  );

  // Divide by 100.
  lfos_div100 u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s2_valid  (s2_valid),
    .s2_plan   (s2_plan),
    .s2_prod_p (s2_prod_p),
    .s2_prod_d (s2_prod_d),
    .s3_valid  (s3_valid),
    .s3_plan   (s3_plan),
    .s3_quot_p (s3_quot_p),
    .s3_quot_d (s3_quot_d)
  );

  // Result stage and command issue.
  lfos_out u_out (
    .clk          (clk),
    .rst          (rst),
    .cruise_speed (cruise_speed),
    .s3_valid     (s3_valid),
    .s3_plan      (s3_plan),
    .s3_quot_p    (s3_quot_p),
    .s3_quot_d    (s3_quot_d),
    .out_ready    (out_ready),
    .adv          (adv),
    .out_valid    (out_valid),
    .motor_action (motor_action),
    .left_speed   (left_speed),
    .right_speed  (right_speed),
    .hold_ms      (hold_ms),
    .last         (last)
  );

endmodule

@@ hw/rtl/lfos_checker.sv @@
// Port-level checks for the line follow / obstacle sequencer.
// Bound to line_follow_obstacle_sequencer_core; depends on lfos_pkg.
`timescale 1ns / 1ps

module lfos_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [31:0]        now_ms,
  input logic [8:0]         distance_cm,
  input logic [7:0]         line_sensors,
  input logic signed [12:0] line_position,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         motor_action,
  input logic signed [9:0]  left_speed,
  input logic signed [9:0]  right_speed,
  input logic [8:0]         hold_ms,
  input logic               last,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [15:0]        cfg_data
);

  // A stalled command keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(motor_action) && $stable(hold_ms)
      && $stable(left_speed) && $stable(right_speed) && $stable(last))
    else $error("stalled command changed");

  // The commands of one request follow each other without a gap.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("gap inside a command burst");

  // A differential command is always the only command of its request.
  a_diff_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_action == lfos_pkg::ACT_DIFF |-> last)
    else $error("differential command not final");

  // Stop commands carry zero speed.
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_action == lfos_pkg::ACT_STOP |-> left_speed == 0 && right_speed == 0)
    else $error("stop command with nonzero speed");

  // With no command pending the block takes a new request.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

endmodule

bind line_follow_obstacle_sequencer_core lfos_checker u_lfos_checker (.*);

@@ test/lfos_result_checker.sv @@
// Result checker for the line follow / obstacle sequencer testbench.
// Watches the request, result and register channels, predicts the motor commands
// of every accepted request and compares them in order. Depends on lfos_pkg.
`timescale 1ns / 1ps

module lfos_result_checker
  import lfos_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [31:0]        now_ms,
  input  logic [8:0]         distance_cm,
  input  logic [7:0]         line_sensors,
  input  logic signed [12:0] line_position,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         motor_action,
  input  logic signed [9:0]  left_speed,
  input  logic signed [9:0]  right_speed,
  input  logic [8:0]         hold_ms,
  input  logic               last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  localparam int PCT_DIV     = 100;
  localparam int SPEED_LIMIT = 511;

  typedef struct packed {
    action_t           act;
    logic signed [9:0] left;
    logic signed [9:0] right;
    logic [8:0]        hold;
    logic              last;
  } motor_cmd_t;

  // Shadow copy of the configuration registers.
  logic [9:0]  gain_p;
  logic [9:0]  gain_d;
  logic [7:0]  cruise_speed;
  logic [8:0]  obstacle_cm;
  logic [15:0] turn_ms;
  logic [15:0] search_ms;

  // Predicted controller state.
  mode_t              mode;
  logic               turn_right;
  logic signed [12:0] prev_error;
  logic [31:0]        phase_start;

  motor_cmd_t  expected_cmds[$];
  int unsigned cmd_index;

  // A command with fixed speeds: cruise speed when moving, zero on stop.
  function automatic motor_cmd_t fixed_cmd(action_t act, logic [8:0] hold);
    motor_cmd_t c;
    c.act   = act;
    c.left  = (act == ACT_STOP) ? 10'sd0 : $signed({2'b00, cruise_speed});
    c.right = c.left;
    c.hold  = hold;
    c.last  = 1'b0;
    return c;
  endfunction

  function automatic logic signed [9:0] clamp_speed(int v);
    if (v > SPEED_LIMIT) return 10'(SPEED_LIMIT);
    if (v < -SPEED_LIMIT) return 10'(-SPEED_LIMIT);
    return 10'(v);
  endfunction

  task automatic flip_turn_side();
    turn_right = ~turn_right;
    mode = turn_right ? MODE_TURN_R : MODE_TURN_L;
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Works out the commands of one control step and advances the predicted state.
  task automatic predict_motor_cmds(input logic [31:0] now, input logic [8:0] dist_cm,
                                    input logic [7:0] sens,
                                    input logic signed [12:0] pos);
    motor_cmd_t  cmds [3];
    logic [31:0] elapsed;
    int          n;
    int          err;
    int          derr;
    int          adj;
    int          gp;
    int          gd;
    int          base;
    n = 0;
    elapsed = now - phase_start;
    case (mode)
      MODE_FOLLOW: begin
        if (dist_cm < obstacle_cm) begin
          // Obstacle: stop, back off, settle, then turn to the other side.
          cmds[0] = fixed_cmd(ACT_STOP, HOLD_OBST_STOP);
          cmds[1] = fixed_cmd(ACT_REV, HOLD_REVERSE);
          cmds[2] = fixed_cmd(ACT_STOP, HOLD_SETTLE);
          n = 3;
          flip_turn_side();
          phase_start = now + OBST_SEQ_MS;
        end else begin
          // PD steering; each term truncates toward zero.
          err  = pos;
          derr = err - prev_error;
          gp   = gain_p;
          gd   = gain_d;
          base = cruise_speed;
          adj  = (gp * err) / PCT_DIV + (gd * derr) / PCT_DIV;
          cmds[0].act   = ACT_DIFF;
          cmds[0].left  = clamp_speed(base - adj);
          cmds[0].right = clamp_speed(base + adj);
          cmds[0].hold  = HOLD_NONE;
          cmds[0].last  = 1'b0;
          n = 1;
          prev_error = pos;
        end
      end
      MODE_TURN_R, MODE_TURN_L: begin
        cmds[0] = fixed_cmd((mode == MODE_TURN_R) ? ACT_SPIN_R : ACT_SPIN_L, HOLD_NONE);
        n = 1;
        if (elapsed > {16'd0, turn_ms}) begin
          cmds[1] = fixed_cmd(ACT_FWD, HOLD_NONE);
          n = 2;
          mode = MODE_SEARCH;
          phase_start = now;
        end
      end
      default: begin
        // Search: any sensor ends it, otherwise a timeout turns the other way.
        cmds[0] = fixed_cmd(ACT_FWD, HOLD_NONE);
        n = 1;
        if ((sens & SENSOR_MASK) != '0) begin
          cmds[1] = fixed_cmd(ACT_FWD, HOLD_NONE);
          n = 2;
          mode = MODE_FOLLOW;
        end else if (elapsed > {16'd0, search_ms}) begin
          cmds[1] = fixed_cmd(ACT_STOP, HOLD_SETTLE);
          n = 2;
          flip_turn_side();
          phase_start = now + SETTLE_MS;
        end
      end
    endcase
    cmds[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_cmds.push_back(cmds[i]);
  endtask

  // Sample all channels at the clock edge; results are compared before new
  // requests are predicted.
  always @(posedge clk) begin : watch
    motor_cmd_t want;
    if (rst) begin
      gain_p       = GAIN_P_RST;
      gain_d       = GAIN_D_RST;
      cruise_speed = CRUISE_SPEED_RST;
      obstacle_cm  = OBSTACLE_CM_RST;
      turn_ms      = TURN_MS_RST;
      search_ms    = SEARCH_MS_RST;
      mode         = MODE_FOLLOW;
      turn_right   = 1'b1;
      prev_error   = '0;
      phase_start  = '0;
      cmd_index    = 0;
      errors       = 0;
      expected_cmds.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("command %0d arrived with nothing expected, action %0d",
                                    cmd_index, motor_action));
        end else begin
          want = expected_cmds.pop_front();
          if (motor_action !== want.act)
            report_mismatch($sformatf("command %0d action %0d, expected %0d",
                                      cmd_index, motor_action, want.act));
          if (left_speed !== want.left)
            report_mismatch($sformatf("command %0d left speed %0d, expected %0d",
                                      cmd_index, left_speed, want.left));
          if (right_speed !== want.right)
            report_mismatch($sformatf("command %0d right speed %0d, expected %0d",
                                      cmd_index, right_speed, want.right));
          if (hold_ms !== want.hold)
            report_mismatch($sformatf("command %0d hold %0d, expected %0d",
                                      cmd_index, hold_ms, want.hold));
          if (last !== want.last)
            report_mismatch($sformatf("command %0d last %0b, expected %0b",
                                      cmd_index, last, want.last));
        end
        cmd_index++;
      end

      // Register writes; indexes beyond the list are ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P:       gain_p       = cfg_data[9:0];
          REG_GAIN_D:       gain_d       = cfg_data[9:0];
          REG_CRUISE_SPEED: cruise_speed = cfg_data[7:0];
          REG_OBSTACLE_CM:  obstacle_cm  = cfg_data[8:0];
          REG_TURN_MS:      turn_ms      = cfg_data;
          REG_SEARCH_MS:    search_ms    = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready)
        predict_motor_cmds(now_ms, distance_cm, line_sensors, line_position);
    end
    pending = expected_cmds.size();
  end

endmodule

@@ test/tb_line_follow_obstacle_sequencer_core.sv @@
// Testbench top for line_follow_obstacle_sequencer_core: clock, reset, request and
// register stimulus with random gaps, random result stalls, and the final verdict.
// Depends on lfos_pkg, the block and lfos_result_checker.
`timescale 1ns / 1ps

module tb_line_follow_obstacle_sequencer_core;
  import lfos_pkg::*;

  localparam int          TIMEOUT_NS    = 10_000_000;
  localparam int          SETTLE_CYCLES = 20;
  localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI  = 3'd7;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [31:0]        now_ms        = '0;
  logic [8:0]         distance_cm   = '0;
  logic [7:0]         line_sensors  = '0;
  logic signed [12:0] line_position = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [2:0]         motor_action;
  logic signed [9:0]  left_speed;
  logic signed [9:0]  right_speed;
  logic [8:0]         hold_ms;
  logic               last;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index     = '0;
  logic [15:0]        cfg_data      = '0;

  int check_errors;
  int check_pending;

  // Stimulus-side view of the timing registers, used to pace timestamps.
  logic [8:0]  obst_shadow   = OBSTACLE_CM_RST;
  logic [15:0] turn_shadow   = TURN_MS_RST;
  logic [15:0] search_shadow = SEARCH_MS_RST;
  logic [31:0] robot_ms      = '0;
  bit          in_gaps_on    = 1'b1;

  // Result-side stall pattern state.
  int ready_left  = 0;
  bit ready_level = 1'b0;

  always #5 clk = ~clk;

  line_follow_obstacle_sequencer_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_ms        (now_ms),
    .distance_cm   (distance_cm),
    .line_sensors  (line_sensors),
    .line_position (line_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .motor_action  (motor_action),
    .left_speed    (left_speed),
    .right_speed   (right_speed),
    .hold_ms       (hold_ms),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lfos_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_ms        (now_ms),
    .distance_cm   (distance_cm),
    .line_sensors  (line_sensors),
    .line_position (line_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .motor_action  (motor_action),
    .left_speed    (left_speed),
    .right_speed   (right_speed),
    .hold_ms       (hold_ms),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (check_errors),
    .pending       (check_pending)
  );

  // Result stalls: mostly short, a few long, with occasional long stall-free runs.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_level = !ready_level;
      if (ready_level)
        ready_left = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 8);
      else
        ready_left = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 50);
    end
    ready_left--;
    out_ready <= ready_level;
  end

  function automatic int pick_gap();
    int r;
    if (!in_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Presents one control step request and returns at the edge that accepts it.
  task automatic send_step(input logic [31:0] now, input logic [8:0] dist_cm,
                           input logic [7:0] sens, input logic signed [12:0] pos);
    int gap;
    bit ok;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    now_ms        <= now;
    distance_cm   <= dist_cm;
    line_sensors  <= sens;
    line_position <= pos;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_OBSTACLE_CM: obst_shadow   = data[8:0];
      REG_TURN_MS:     turn_shadow   = data;
      REG_SEARCH_MS:   search_shadow = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] gp, input logic [15:0] gd,
                           input logic [15:0] bs, input logic [15:0] ob,
                           input logic [15:0] tm, input logic [15:0] sm);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_CRUISE_SPEED, bs);
    write_reg(REG_OBSTACLE_CM, ob);
    write_reg(REG_TURN_MS, tm);
    write_reg(REG_SEARCH_MS, sm);
  endtask

  // Stops requests and waits until every predicted command has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (check_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random step: timestamps advance on the scale of the configured times so
  // that turns and searches both expire and get cut short.
  task automatic send_random_step();
    int                 r;
    int                 span;
    logic [8:0]         range_cm;
    logic [7:0]         sens;
    logic signed [12:0] pos;
    span = (turn_shadow > search_shadow) ? turn_shadow : search_shadow;
    r = $urandom_range(0, 99);
    if (r < 5) robot_ms = $urandom();
    else robot_ms = robot_ms + $urandom_range(0, span / 2 + 5);

    r = $urandom_range(0, 99);
    if (r < 15 && obst_shadow != 0) range_cm = $urandom_range(0, obst_shadow - 1);
    else if (r < 25) range_cm = $urandom_range(0, 511);
    else range_cm = $urandom_range(obst_shadow, 511);

    r = $urandom_range(0, 99);
    if (r < 10) sens = $urandom_range(0, 255);
    else if (r < 15) sens = 8'(1 << $urandom_range(0, 7));
    else sens = '0;

    r = $urandom_range(0, 99);
    if (r < 65) pos = 13'(int'($urandom_range(0, 600)) - 300);
    else if (r < 90) pos = 13'($urandom_range(0, 8191));
    else pos = ($urandom_range(0, 1) != 0) ? 13'sd4095 : 13'sh1000;

    send_step(robot_ms, range_cm, sens, pos);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Writes to indexes past the register list must change nothing.
    write_reg(REG_SPARE_LO, 16'h0000);
    write_reg(REG_SPARE_HI, 16'hFFFF);

    // Directed steps at the reset settings.
    send_step(32'd1000, 9'd100, 8'h00, 13'sd0);
    send_step(32'd1010, 9'd100, 8'h00, 13'sd4095);     // positive saturation
    send_step(32'd1020, 9'd100, 8'h00, 13'sh1000);     // most negative error
    send_step(32'd1030, 9'd100, 8'h00, 13'sd4095);     // largest error change
    send_step(32'd1040, 9'd100, 8'h00, -13'sd1);       // small negative error
    send_step(32'd1050, 9'd100, 8'h00, 13'sd37);
    send_step(32'd1060, 9'd15, 8'h00, 13'sd0);         // distance at the threshold
    send_step(32'd1070, 9'd511, 8'hFF, 13'sd0);
    send_step(32'd1080, 9'd14, 8'h00, 13'sd0);         // obstacle, turn left
    send_step(32'd1880, 9'd14, 8'h00, 13'sd0);         // turn just started
    send_step(32'd2680, 9'd100, 8'h00, 13'sd0);        // turn time reached, not passed
    send_step(32'd2681, 9'd100, 8'h00, 13'sd0);        // turn over, search
    send_step(32'd2700, 9'd0, 8'h00, 13'sd0);
    send_step(32'd4681, 9'd100, 8'h00, 13'sd0);        // search time reached
    send_step(32'd4682, 9'd100, 8'h00, 13'sd0);        // search timeout, turn right
    send_step(32'd4700, 9'd100, 8'h00, 13'sd0);        // timestamp before phase start
    send_step(32'd4800, 9'd100, 8'h01, 13'sd0);        // line found
    send_step(32'hFFFF_FF00, 9'd0, 8'h00, 13'sd0);     // obstacle, phase start wraps
    send_step(32'hFFFF_FFFF, 9'd100, 8'h00, 13'sd0);
    send_step(32'h0000_0100, 9'd100, 8'h80, 13'sd0);   // line found across the wrap
    send_step(32'h0000_0200, 9'd300, 8'h00, 13'sd100);
    robot_ms = 32'h0000_0300;

    // Random steps at the reset settings.
    for (int i = 0; i < 100; i++) send_random_step();
    drain();

    // Every register at its top value, masked from all-ones data, no request gaps.
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    in_gaps_on = 1'b0;
    for (int i = 0; i < 60; i++) send_random_step();
    drain();
    in_gaps_on = 1'b1;

    // Every register at zero.
    configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 40; i++) send_random_step();
    drain();

    // Moderate random settings.
    configure(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
              16'($urandom_range(0, 255)), 16'($urandom_range(5, 60)),
              16'($urandom_range(0, 3000)), 16'($urandom_range(0, 5000)));
    for (int i = 0; i < 125; i++) send_random_step();
    drain();

    // Fully random data on every register and on a spare index.
    configure(16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()), 16'($urandom()), 16'($urandom()));
    write_reg(REG_SPARE_HI, 16'($urandom()));
    for (int i = 0; i < 125; i++) send_random_step();
    drain();

    if (check_errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
